// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  typedef logic [2:0]            mode_t;
  typedef logic [2:0]            status_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_READ       = 3'd4;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_INVALID = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_FULL    = 3'd3;
  localparam status_t ST_RANGE   = 3'd4;

  localparam count_t COUNT_FULL = count_t'(DEPTH);

  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

  typedef struct packed {
    status_t status;
    count_t  occupancy;
    logic    use_rdata;
  } result_info_t;

endpackage

// ===== rtl/dq_ram.sv =====
module dq_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] addr,
  input  logic [WIDTH_P-1:0]         wdata,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/dq_ctrl.sv =====
module dq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  dq_pkg::mode_t        mode,
  input  logic [31:0]          payload,
  input  logic [7:0]           position,
  output dq_pkg::mem_req_t     mem_req,
  output dq_pkg::result_info_t info
);
  import dq_pkg::*;

  addr_t  front, front_next;
  count_t count, count_next;
  word_t  word;
  count_t last;

  assign word = payload[DATA_WIDTH-1:0];
  assign last = count - count_t'(1);

  always_comb begin
    front_next     = front;
    count_next     = count;
    mem_req.we     = 1'b0;
    mem_req.re     = 1'b0;
    mem_req.addr   = front;
    mem_req.wdata  = word;
    info.status    = ST_OK;
    info.use_rdata = 1'b0;
    unique case (mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (word == '0) begin
          info.status = ST_INVALID;
        end else if (count == COUNT_FULL) begin
          info.status = ST_FULL;
        end else begin
          mem_req.we = fire;
          count_next = count + count_t'(1);
          if (mode == MODE_PUSH_FRONT) begin
            front_next   = front - addr_t'(1);
            mem_req.addr = front - addr_t'(1);
          end else begin
            mem_req.addr = front + count[ADDR_W-1:0];
          end
        end
      end
      MODE_POP_FRONT: begin
        if (count == '0) begin
          info.status = ST_EMPTY;
        end else begin
          mem_req.re     = fire;
          info.use_rdata = 1'b1;
          front_next     = front + addr_t'(1);
          count_next     = last;
        end
      end
      MODE_POP_BACK: begin
        if (count == '0) begin
          info.status = ST_EMPTY;
        end else begin
          mem_req.re     = fire;
          mem_req.addr   = front + last[ADDR_W-1:0];
          info.use_rdata = 1'b1;
          count_next     = last;
        end
      end
      MODE_READ: begin
        if (count_t'(position) >= count) begin
          info.status = ST_RANGE;
        end else begin
          mem_req.re     = fire;
          mem_req.addr   = front + addr_t'(position);
          info.use_rdata = 1'b1;
        end
      end
      default: begin
        info.status = ST_INVALID;
      end
    endcase
    info.occupancy = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (fire) begin
      front <= front_next;
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("entry count above depth");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    fire && info.status == ST_FULL |=> count == COUNT_FULL)
    else $error("full push changed the count");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("read and write in the same cycle");

endmodule

// ===== rtl/double_ended_queue.sv =====
// An accepted request word sets the pending flag while the entry memory reads;
// the result word is then registered onto out_valid and the result outputs. A new
// request word is held off while one is pending or while out_valid waits on out_ready.
// Reset: synchronous, active high; the queue comes up empty with the front
// pointer at zero. Entry memory contents are not cleared.
module double_ended_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dq_pkg::mode_t         mode,
  input  logic [31:0]           payload,
  input  logic [7:0]            position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dq_pkg::status_t       status,
  output logic [31:0]           result_data,
  output logic [8:0]            occupancy
);
  import dq_pkg::*;

  logic         fire;
  logic         pending;
  mem_req_t     mem_req;
  result_info_t info, pend_info;
  word_t        rdata;

  assign in_ready = !pending && (!out_valid || out_ready);
  assign fire     = in_valid && in_ready;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .mode     (mode),
    .payload  (payload),
    .position (position),
    .mem_req  (mem_req),
    .info     (info)
  );

  dq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pending <= fire;
      if (pending) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      pend_info <= info;
    end
    if (pending) begin
      status      <= pend_info.status;
      occupancy   <= 9'(pend_info.occupancy);
      result_data <= pend_info.use_rdata ? 32'(rdata) : '0;
    end
  end

  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    fire |=> pending && !in_ready)
    else $error("accepted word not in flight");

  a_pending_result: assert property (@(posedge clk) disable iff (rst)
    pending |=> out_valid)
    else $error("result word not presented");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_data == '0)
    else $error("error result carries data");

endmodule
